@@ rtl/tcgr_pkg.sv @@
// Shared types, codes and constants of the text cell glyph renderer.
package tcgr_pkg;

   localparam logic [1:0] OP_GLYPH = 2'd0;
   localparam logic [1:0] OP_TEXT  = 2'd1;
   localparam logic [1:0] OP_PIXEL = 2'd2;

   localparam logic [1:0] REG_RATIO       = 2'd0;
   localparam logic [1:0] REG_TEXT_WIDTH  = 2'd1;
   localparam logic [1:0] REG_TEXT_HEIGHT = 2'd2;

   localparam logic [3:0]  RATIO_RESET       = 4'd4;
   localparam logic [10:0] TEXT_WIDTH_RESET  = 11'd256;
   localparam logic [10:0] TEXT_HEIGHT_RESET = 11'd256;

   // Fraction bits of the reciprocal used to divide by the ratio.
   localparam int RECIP_SHIFT = 16;

   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic [1:0]  op;
      logic [6:0]  glyph_code;
      logic [2:0]  glyph_row;
      logic [2:0]  glyph_col;
      logic [7:0]  glyph_value;
      logic [9:0]  text_x;
      logic [9:0]  text_y;
      logic [7:0]  char_code;
      logic [12:0] pixel_x;
      logic [12:0] pixel_y;
   } req_type;

   typedef struct packed {
      logic [7:0] pixel_value;
      logic       out_of_range;
   } rsp_type;

   // Settings and the values derived from them.
   typedef struct packed {
      logic [3:0]  ratio;        // effective ratio, never zero
      logic [16:0] recip;        // ceil(2^RECIP_SHIFT / ratio)
      logic [10:0] text_width;
      logic [10:0] text_height;
      logic [10:0] grid_cols;
      logic [10:0] grid_rows;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      ratio:       RATIO_RESET,
      recip:       17'd16384,
      text_width:  TEXT_WIDTH_RESET,
      text_height: TEXT_HEIGHT_RESET,
      grid_cols:   11'd64,
      grid_rows:   11'd64
   };

   // Classified request handed from the front end to the back end.
   typedef struct packed {
      logic [1:0]  op;
      logic        ok;     // glyph write in range, text char inside the text area, or pixel read
      logic [12:0] col_q;  // cell column
      logic [12:0] row_q;  // cell row
      logic [9:0]  col_n;  // text x, glyph column or column inside the glyph
      logic [9:0]  row_n;  // text y, glyph row or row inside the glyph
      logic [7:0]  data;   // glyph grey value or character code
      logic [6:0]  code;   // glyph code of a glyph write
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_stat_type;

   function automatic logic [16:0] recip_of(input logic [3:0] r);
      logic [16:0] m;
      case (r)
         4'd2:    m = 17'd32768;
         4'd3:    m = 17'd21846;
         4'd4:    m = 17'd16384;
         4'd5:    m = 17'd13108;
         4'd6:    m = 17'd10923;
         4'd7:    m = 17'd9363;
         4'd8:    m = 17'd8192;
         4'd9:    m = 17'd7282;
         4'd10:   m = 17'd6554;
         4'd11:   m = 17'd5958;
         4'd12:   m = 17'd5462;
         4'd13:   m = 17'd5042;
         4'd14:   m = 17'd4682;
         4'd15:   m = 17'd4370;
         default: m = 17'd65536;
      endcase
      return m;
   endfunction

endpackage

@@ rtl/tcgr_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
module tcgr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/tcgr_front.sv @@
// Front end: accepts requests, decodes them and computes cell coordinates.
module tcgr_front #(
   parameter int GLYPHS  = 128,
   parameter int GLYPH_W = 8,
   parameter int GLYPH_H = 8
) (
   input  logic                 req_valid,
   output logic                 req_ready,
   input  tcgr_pkg::req_type    req_payload,
   input  tcgr_pkg::cfg_type    cfg,
   input  tcgr_pkg::q_stat_type q_stat,
   output logic                 q_push,
   output tcgr_pkg::cmd_type    q_cmd
);

   localparam int          DIV_SHIFT = 19;
   localparam logic [19:0] RECIP_W   = 20'((2 ** DIV_SHIFT + GLYPH_W - 1) / GLYPH_W);
   localparam logic [19:0] RECIP_H   = 20'((2 ** DIV_SHIFT + GLYPH_H - 1) / GLYPH_H);

   logic [26:0] text_x_prod;
   logic [26:0] text_y_prod;
   logic [32:0] pix_x_prod;
   logic [32:0] pix_y_prod;
   logic [12:0] pix_x_quot;
   logic [12:0] pix_y_quot;
   logic [17:0] pix_x_base;
   logic [17:0] pix_y_base;
   logic        op_known;

   // Divide the text coordinates by the ratio through its reciprocal.
   assign text_x_prod = 27'(req_payload.text_x) * 27'(cfg.recip);
   assign text_y_prod = 27'(req_payload.text_y) * 27'(cfg.recip);

   // Split the pixel position into cell and offset through the glyph size reciprocal.
   assign pix_x_prod = 33'(req_payload.pixel_x) * 33'(RECIP_W);
   assign pix_y_prod = 33'(req_payload.pixel_y) * 33'(RECIP_H);
   assign pix_x_quot = pix_x_prod[DIV_SHIFT+12:DIV_SHIFT];
   assign pix_y_quot = pix_y_prod[DIV_SHIFT+12:DIV_SHIFT];
   assign pix_x_base = 18'(pix_x_quot) * 18'(GLYPH_W);
   assign pix_y_base = 18'(pix_y_quot) * 18'(GLYPH_H);

   always_comb begin
      q_cmd    = '0;
      q_cmd.op = req_payload.op;
      op_known = 1'b1;
      case (req_payload.op)
         tcgr_pkg::OP_GLYPH: begin
            q_cmd.ok    = (9'(req_payload.glyph_code) < 9'(GLYPHS))
                       && (6'(req_payload.glyph_row) < 6'(GLYPH_H))
                       && (6'(req_payload.glyph_col) < 6'(GLYPH_W));
            q_cmd.col_n = 10'(req_payload.glyph_col);
            q_cmd.row_n = 10'(req_payload.glyph_row);
            q_cmd.data  = req_payload.glyph_value;
            q_cmd.code  = req_payload.glyph_code;
         end
         tcgr_pkg::OP_TEXT: begin
            q_cmd.ok    = (11'(req_payload.text_x) < cfg.text_width)
                       && (11'(req_payload.text_y) < cfg.text_height);
            q_cmd.col_q = 13'(text_x_prod[tcgr_pkg::RECIP_SHIFT+9:tcgr_pkg::RECIP_SHIFT]);
            q_cmd.row_q = 13'(text_y_prod[tcgr_pkg::RECIP_SHIFT+9:tcgr_pkg::RECIP_SHIFT]);
            q_cmd.col_n = req_payload.text_x;
            q_cmd.row_n = req_payload.text_y;
            q_cmd.data  = req_payload.char_code;
         end
         tcgr_pkg::OP_PIXEL: begin
            q_cmd.ok    = 1'b1;
            q_cmd.col_q = pix_x_quot;
            q_cmd.row_q = pix_y_quot;
            q_cmd.col_n = 10'(18'(req_payload.pixel_x) - pix_x_base);
            q_cmd.row_n = 10'(18'(req_payload.pixel_y) - pix_y_base);
         end
         default: begin
            op_known = 1'b0;
         end
      endcase
   end

   assign req_ready = !q_stat.full;
   // Drop the unused op code here.
   assign q_push    = req_valid && req_ready && op_known;

endmodule

@@ rtl/tcgr_queue.sv @@
// Short queue of classified requests between the front and the back end.
module tcgr_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  tcgr_pkg::cmd_type    push_cmd,
   input  logic                 pop,
   output tcgr_pkg::cmd_type    head_cmd,
   output tcgr_pkg::q_stat_type stat
);

   tcgr_pkg::cmd_type                entry_ff [tcgr_pkg::QUEUE_DEPTH];
   logic [tcgr_pkg::QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [tcgr_pkg::QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [tcgr_pkg::QUEUE_CNT_W-1:0] count_ff, count_in;

   localparam logic [tcgr_pkg::QUEUE_PTR_W-1:0] LAST_PTR =
      tcgr_pkg::QUEUE_PTR_W'(tcgr_pkg::QUEUE_DEPTH - 1);
   localparam logic [tcgr_pkg::QUEUE_CNT_W-1:0] FULL_COUNT =
      tcgr_pkg::QUEUE_CNT_W'(tcgr_pkg::QUEUE_DEPTH);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   assign head_cmd   = entry_ff[rd_ptr_ff];
   assign stat.full  = (count_ff == FULL_COUNT);
   assign stat.empty = (count_ff == '0);

endmodule

@@ rtl/tcgr_back.sv @@
// Back end: sequences cell and glyph memory accesses and holds the response.
module tcgr_back #(
   parameter int GLYPHS    = 128,
   parameter int GLYPH_W   = 8,
   parameter int GLYPH_H   = 8,
   parameter int MAX_CELLS = 4096
) (
   input  logic                 clock,
   input  logic                 reset,
   input  tcgr_pkg::cfg_type    cfg,
   input  tcgr_pkg::q_stat_type q_stat,
   input  tcgr_pkg::cmd_type    q_head,
   output logic                 q_pop,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output tcgr_pkg::rsp_type    rsp_payload
);

   localparam int GLYPH_DEPTH = GLYPHS * GLYPH_H * GLYPH_W;
   localparam int GA_W        = $clog2(GLYPH_DEPTH);
   localparam int CA_W        = $clog2(MAX_CELLS);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_MUL   = 3'd1;
   localparam logic [2:0] S_ADDR  = 3'd2;
   localparam logic [2:0] S_CELL  = 3'd3;
   localparam logic [2:0] S_GLYPH = 3'd4;
   localparam logic [2:0] S_OUT   = 3'd5;

   logic [2:0]        state_ff, state_in;
   tcgr_pkg::cmd_type cmd_ff, cmd_in;
   logic [13:0]       prod_x_ff, prod_x_in;
   logic [13:0]       prod_y_ff, prod_y_in;
   logic [23:0]       idx_mul_ff, idx_mul_in;
   logic              in_grid_ff, in_grid_in;
   tcgr_pkg::rsp_type res_ff, res_in;
   logic              rsp_valid_ff, rsp_valid_in;
   tcgr_pkg::rsp_type rsp_payload_ff, rsp_payload_in;

   logic [24:0]     idx_sum;
   logic            idx_ok;
   logic            text_hit;
   logic            code_ok;
   logic            rsp_load;
   logic [7:0]      g_code;
   logic [31:0]     g_addr_full;
   logic [GA_W-1:0] glyph_addr;
   logic [CA_W-1:0] cell_addr;
   logic            cell_we, cell_re, glyph_we, glyph_re;
   logic [7:0]      cell_rdata, glyph_rdata;

   assign idx_sum   = 25'(idx_mul_ff) + 25'(cmd_ff.col_q);
   assign idx_ok    = idx_sum < 25'(MAX_CELLS);
   assign cell_addr = CA_W'(idx_sum);
   // A text char is kept only on ratio multiples that land inside the grid.
   assign text_hit  = cmd_ff.ok && in_grid_ff && idx_ok
                   && (prod_x_ff == 14'(cmd_ff.col_n))
                   && (prod_y_ff == 14'(cmd_ff.row_n));
   assign code_ok   = 9'(cell_rdata) < 9'(GLYPHS);

   assign g_code      = (state_ff == S_CELL) ? cell_rdata : 8'(cmd_ff.code);
   assign g_addr_full = (32'(g_code) * 32'(GLYPH_H) + 32'(cmd_ff.row_n[4:0]))
                      * 32'(GLYPH_W) + 32'(cmd_ff.col_n[4:0]);
   assign glyph_addr  = GA_W'(g_addr_full);

   assign cell_we  = (state_ff == S_ADDR) && (cmd_ff.op == tcgr_pkg::OP_TEXT) && text_hit;
   assign cell_re  = (state_ff == S_ADDR) && (cmd_ff.op == tcgr_pkg::OP_PIXEL)
                  && in_grid_ff && idx_ok;
   assign glyph_we = (state_ff == S_ADDR) && (cmd_ff.op == tcgr_pkg::OP_GLYPH) && cmd_ff.ok;
   assign glyph_re = (state_ff == S_CELL) && code_ok;

   assign rsp_load = (state_ff == S_OUT) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      state_in   = state_ff;
      cmd_in     = cmd_ff;
      prod_x_in  = prod_x_ff;
      prod_y_in  = prod_y_ff;
      idx_mul_in = idx_mul_ff;
      in_grid_in = in_grid_ff;
      res_in     = res_ff;
      q_pop      = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (!q_stat.empty) begin
               q_pop    = 1'b1;
               cmd_in   = q_head;
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            prod_x_in  = 14'(cmd_ff.col_q[9:0]) * 14'(cfg.ratio);
            prod_y_in  = 14'(cmd_ff.row_q[9:0]) * 14'(cfg.ratio);
            idx_mul_in = 24'(cmd_ff.row_q) * 24'(cfg.grid_cols);
            in_grid_in = (cmd_ff.col_q < 13'(cfg.grid_cols))
                      && (cmd_ff.row_q < 13'(cfg.grid_rows));
            state_in   = S_ADDR;
         end
         S_ADDR: begin
            if (cmd_ff.op == tcgr_pkg::OP_PIXEL) begin
               if (in_grid_ff && idx_ok) begin
                  state_in = S_CELL;
               end else begin
                  res_in   = '{pixel_value: 8'd0, out_of_range: 1'b1};
                  state_in = S_OUT;
               end
            end else begin
               state_in = S_IDLE;
            end
         end
         S_CELL: begin
            if (code_ok) begin
               state_in = S_GLYPH;
            end else begin
               res_in   = '{pixel_value: 8'd0, out_of_range: 1'b1};
               state_in = S_OUT;
            end
         end
         S_GLYPH: begin
            res_in   = '{pixel_value: glyph_rdata, out_of_range: 1'b0};
            state_in = S_OUT;
         end
         S_OUT: begin
            if (rsp_load) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in   = rsp_valid_ff;
      rsp_payload_in = rsp_payload_ff;
      if (rsp_load) begin
         rsp_valid_in   = 1'b1;
         rsp_payload_in = res_ff;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff         <= cmd_in;
      prod_x_ff      <= prod_x_in;
      prod_y_ff      <= prod_y_in;
      idx_mul_ff     <= idx_mul_in;
      in_grid_ff     <= in_grid_in;
      res_ff         <= res_in;
      rsp_payload_ff <= rsp_payload_in;
   end

   tcgr_ram #(
      .WIDTH (8),
      .DEPTH (MAX_CELLS)
   ) u_cell_ram (
      .clock   (clock),
      .wr_en   (cell_we),
      .wr_addr (cell_addr),
      .wr_data (cmd_ff.data),
      .rd_en   (cell_re),
      .rd_addr (cell_addr),
      .rd_data (cell_rdata)
   );

   tcgr_ram #(
      .WIDTH (8),
      .DEPTH (GLYPH_DEPTH)
   ) u_glyph_ram (
      .clock   (clock),
      .wr_en   (glyph_we),
      .wr_addr (glyph_addr),
      .wr_data (cmd_ff.data),
      .rd_en   (glyph_re),
      .rd_addr (glyph_addr),
      .rd_data (glyph_rdata)
   );

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

@@ rtl/text_cell_glyph_renderer.sv @@
// Top level of the text cell glyph renderer: settings registers and block wiring.
//
// Text-mode character generator with grid subsampling. Requests either write one
// grey pixel of a glyph, place a character on the text grid (kept only when both
// coordinates are multiples of ratio), or read one output pixel, which returns the
// glyph grey value of the cell under it, or 0 with out_of_range set when the cell is
// outside the grid or cell store or its character has no glyph. The front end decodes
// each request in the cycle it is accepted and queues it (two entries); the back end
// runs one request at a time, its sequencer stepping through the multiply stage and
// the address stage; a pixel read then goes on to the cell RAM read and then the glyph
// RAM read, ending early when its cell is outside the grid or cell store or its
// character has no glyph, and waits while the previous response is still untaken. Glyph
// and cell memories power up undefined and need no clearing pass; read only written
// cells and glyph pixels. Write the settings only while the block is idle.
module text_cell_glyph_renderer #(
   parameter int GLYPHS    = 128,
   parameter int GLYPH_W   = 8,
   parameter int GLYPH_H   = 8,
   parameter int MAX_CELLS = 4096
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  tcgr_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output tcgr_pkg::rsp_type rsp_payload,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [3:0]        paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready
);

   logic [3:0]        ratio_ff, ratio_in;
   logic [10:0]       text_width_ff, text_width_in;
   logic [10:0]       text_height_ff, text_height_in;
   tcgr_pkg::cfg_type cfg_ff, cfg_in;
   logic              csr_write;
   logic [3:0]        eff_ratio;
   logic [16:0]       recip;
   logic [27:0]       cols_prod;
   logic [27:0]       rows_prod;

   tcgr_pkg::q_stat_type q_stat;
   tcgr_pkg::cmd_type    q_cmd;
   tcgr_pkg::cmd_type    q_head;
   logic                 q_push;
   logic                 q_pop;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   always_comb begin
      ratio_in       = ratio_ff;
      text_width_in  = text_width_ff;
      text_height_in = text_height_ff;
      if (csr_write) begin
         case (paddr[3:2])
            tcgr_pkg::REG_RATIO:       ratio_in       = pwdata[3:0];
            tcgr_pkg::REG_TEXT_WIDTH:  text_width_in  = pwdata[10:0];
            tcgr_pkg::REG_TEXT_HEIGHT: text_height_in = pwdata[10:0];
            default: ;
         endcase
      end
   end

   // Derive the grid size from the next settings so it changes with them.
   assign eff_ratio = (ratio_in == 4'd0) ? 4'd1 : ratio_in;
   assign recip     = tcgr_pkg::recip_of(eff_ratio);
   assign cols_prod = 28'(text_width_in) * 28'(recip);
   assign rows_prod = 28'(text_height_in) * 28'(recip);

   always_comb begin
      cfg_in.ratio       = eff_ratio;
      cfg_in.recip       = recip;
      cfg_in.text_width  = text_width_in;
      cfg_in.text_height = text_height_in;
      cfg_in.grid_cols   = cols_prod[tcgr_pkg::RECIP_SHIFT+10:tcgr_pkg::RECIP_SHIFT];
      cfg_in.grid_rows   = rows_prod[tcgr_pkg::RECIP_SHIFT+10:tcgr_pkg::RECIP_SHIFT];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ratio_ff       <= tcgr_pkg::RATIO_RESET;
         text_width_ff  <= tcgr_pkg::TEXT_WIDTH_RESET;
         text_height_ff <= tcgr_pkg::TEXT_HEIGHT_RESET;
         cfg_ff         <= tcgr_pkg::CFG_RESET;
      end else begin
         ratio_ff       <= ratio_in;
         text_width_ff  <= text_width_in;
         text_height_ff <= text_height_in;
         cfg_ff         <= cfg_in;
      end
   end

   always_comb begin
      case (paddr[3:2])
         tcgr_pkg::REG_RATIO:       prdata = 32'(ratio_ff);
         tcgr_pkg::REG_TEXT_WIDTH:  prdata = 32'(text_width_ff);
         tcgr_pkg::REG_TEXT_HEIGHT: prdata = 32'(text_height_ff);
         default:                   prdata = 32'd0;
      endcase
   end

   tcgr_front #(
      .GLYPHS  (GLYPHS),
      .GLYPH_W (GLYPH_W),
      .GLYPH_H (GLYPH_H)
   ) u_front (
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .cfg         (cfg_ff),
      .q_stat      (q_stat),
      .q_push      (q_push),
      .q_cmd       (q_cmd)
   );

   tcgr_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (q_cmd),
      .pop      (q_pop),
      .head_cmd (q_head),
      .stat     (q_stat)
   );

   tcgr_back #(
      .GLYPHS    (GLYPHS),
      .GLYPH_W   (GLYPH_W),
      .GLYPH_H   (GLYPH_H),
      .MAX_CELLS (MAX_CELLS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .q_stat      (q_stat),
      .q_head      (q_head),
      .q_pop       (q_pop),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

`ifndef SYNTHESIS
   a_grid_cols_exact: assert property (@(posedge clock) disable iff (reset)
      (16'(cfg_ff.grid_cols) * 16'(cfg_ff.ratio) <= 16'(text_width_ff))
      && (16'(text_width_ff) < (16'(cfg_ff.grid_cols) + 16'd1) * 16'(cfg_ff.ratio)))
      else $error("grid column count does not match width and ratio");

   a_flagged_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.out_of_range |-> rsp_payload.pixel_value == 8'd0)
      else $error("flagged response carries a nonzero pixel value");

   a_push_not_full: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_stat.full)
      else $error("request pushed into a full queue");

   a_pop_not_empty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_stat.empty)
      else $error("request popped from an empty queue");
`endif

endmodule
